>>> rtl/itcp_pkg.sv
// Package: shared types and constants of the threshold crossing block.
`default_nettype none
package itcp_pkg;
  localparam int MAX_SUB_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int COORD_W = 21;
  localparam int PIX_W = 8;
  localparam int POS_W = 12;
  localparam int KIND_W = 4;
  localparam int TILE_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CELL = 4'd0;
  localparam logic [KIND_W-1:0] KIND_TOP = 4'd1;
  localparam logic [KIND_W-1:0] KIND_BOTTOM = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 4'd4;
  localparam logic [KIND_W-1:0] KIND_TL = 4'd5;
  localparam logic [KIND_W-1:0] KIND_TR = 4'd6;
  localparam logic [KIND_W-1:0] KIND_BL = 4'd7;
  localparam logic [KIND_W-1:0] KIND_BR = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_TEST, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/itcp_item_if.sv
// Interfaces: input item channel and point channel.
`default_nettype none
interface itcp_item_if;
  import itcp_pkg::*;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [PIX_W-1:0] pixel_a;
  logic [PIX_W-1:0] pixel_b;
  logic [PIX_W-1:0] pixel_c;
  logic [PIX_W-1:0] pixel_d;
  logic [POS_W-1:0] cell_col;
  logic [POS_W-1:0] cell_row;
  modport source (output valid, kind, pixel_a, pixel_b, pixel_c, pixel_d,
                  cell_col, cell_row, input ready);
  modport sink (input valid, kind, pixel_a, pixel_b, pixel_c, pixel_d,
                cell_col, cell_row, output ready);
endinterface

interface itcp_point_if;
  import itcp_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

>>> rtl/itcp_divider.sv
// Bit-serial restoring divider: quotient = (num << FRAC_BITS) / den.
`default_nettype none
module itcp_divider
  import itcp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NUM_W = 13
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_ctl_t ctl_in,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [NUM_W-1:0] den,
  output logic busy,
  output logic [NUM_W+FRAC_BITS-1:0] quot
);
  localparam int QW = NUM_W + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  logic [QW-1:0] dividend;
  logic [NUM_W:0] rem;
  logic [NUM_W-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [NUM_W:0] trial;

  assign trial = {rem[NUM_W-1:0], dividend[QW-1]} - {1'b0, dsr};
  assign busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl_in.start) begin
      cnt <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      dividend <= {num, {FRAC_BITS{1'b0}}};
      rem <= '0;
      dsr <= den;
      quot <= '0;
    end else if (busy) begin
      dividend <= {dividend[QW-2:0], 1'b0};
      if (!trial[NUM_W] && dsr != '0) begin
        rem <= trial;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[NUM_W-1:0], dividend[QW-1]};
        quot <= {quot[QW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/iso_threshold_crossing_points_top.sv
// Top level: threshold crossing point generator.
`default_nettype none
// One item at a time. A new request is taken once the last point of the
// current one has moved into the output register. Every border or cell
// crossing starts both bit-serial dividers together and passes through the
// test state, the divider wait and the step state. QW, the quotient width,
// is PIX_W+NW+1+FRAC_BITS, which is 22 at the default parameters. A corner
// needs no division, a border pair is tested once, and an interior cell
// tests each of its 2*(S+1) positions in turn. A consumer that holds off a
// point stalls the walk.
module iso_threshold_crossing_points_top
  import itcp_pkg::*;
#(
  parameter int MAX_SUB_STEPS = MAX_SUB_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  itcp_item_if.sink item,
  itcp_point_if.source point
);
  localparam int ONE = 1 << FRAC_BITS;
  localparam int NW = $clog2(MAX_SUB_STEPS + 1);
  localparam int DW = PIX_W + NW + 1;   // |X1-X0| up to 255*S
  localparam int QW = DW + FRAC_BITS;
  localparam int WW = 40;               // wide signed work width

  logic [PIX_W-1:0] thr;
  logic [4:0] ssteps;
  logic [TILE_W-1:0] tw, th;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 8'd128; ssteps <= 5'd16; tw <= 13'd64; th <= 13'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr <= cfg_data[7:0];
        REG_SUB_STEPS: ssteps <= cfg_data[4:0];
        REG_TILE_WIDTH: tw <= cfg_data;
        REG_TILE_HEIGHT: th <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [KIND_W-1:0] kind;
  logic [PIX_W-1:0] pa, pb, pc, pd;
  logic signed [WW-1:0] bx, by, cxs, cys;
  logic [NW-1:0] s, n;
  logic phase;            // 0: x crossing, 1: y crossing
  logic walked;           // last position tested, no further crossing
  logic signed [WW-1:0] gval;
  logic [NW+FRAC_BITS-1:0] gq;
  logic [DW-1:0] dnum, dden;
  logic signed [WW-1:0] pend_x, pend_y;
  logic [1:0] pend_sel;   // which coordinate takes the quotient
  logic pending;          // a point is waiting to know if it is last
  logic done_all;

  div_ctl_t dctl;
  logic dbusy;
  logic gbusy;
  logic [QW-1:0] dq;

  itcp_divider #(.FRAC_BITS(FRAC_BITS), .NUM_W(DW)) u_div (
    .clk(clk), .rst(rst), .ctl_in(dctl), .num(dnum), .den(dden),
    .busy(dbusy), .quot(dq)
  );
  itcp_divider #(.FRAC_BITS(FRAC_BITS), .NUM_W(NW)) u_gdiv (
    .clk(clk), .rst(rst), .ctl_in(dctl), .num(n), .den(s),
    .busy(gbusy), .quot(gq)
  );

  // crossing test for current n and phase
  logic [DW+1:0] e0, e1, ts;
  logic [NW-1:0] sn;
  always_comb begin
    sn = s - n;
    ts = (DW+2)'(thr) * (DW+2)'(s);
    if (!phase) begin
      e0 = (DW+2)'(pa) * (DW+2)'(sn) + (DW+2)'(pc) * (DW+2)'(n);
      e1 = (DW+2)'(pb) * (DW+2)'(sn) + (DW+2)'(pd) * (DW+2)'(n);
    end else begin
      e0 = (DW+2)'(pa) * (DW+2)'(sn) + (DW+2)'(pb) * (DW+2)'(n);
      e1 = (DW+2)'(pc) * (DW+2)'(sn) + (DW+2)'(pd) * (DW+2)'(n);
    end
  end
  logic hit;
  assign hit = (e0 > ts) != (e1 > ts);

  // divider operands, taken by the divider at the edge that starts it
  always_comb begin
    if (kind == KIND_CELL) begin
      if (e1 > e0) begin dnum = DW'(ts - e0); dden = DW'(e1 - e0); end
      else begin dnum = DW'(e0 - ts); dden = DW'(e0 - e1); end
    end else begin
      if (pb > pa) begin dnum = DW'(thr - pa); dden = DW'(pb - pa); end
      else begin dnum = DW'(pa - thr); dden = DW'(pa - pb); end
    end
  end

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [WW-1:0] v);
    if (v > WW'(signed'(1048575))) return 21'sh0FFFFF;
    if (v < -WW'(signed'(1048576))) return 21'sh100000;
    return v[COORD_W-1:0];
  endfunction

  logic out_v;
  logic signed [COORD_W-1:0] ox_r, oy_r;
  logic olast;
  assign point.valid = out_v;
  assign point.point_x = ox_r;
  assign point.point_y = oy_r;
  assign point.last_point = olast;
  assign item.ready = state == ST_IDLE && !pending;

  logic [2:0] above_cnt;
  logic cnt_ok;
  assign above_cnt = 3'(pa > thr) + 3'(pb > thr) + 3'(pc > thr) + 3'(pd > thr);
  assign cnt_ok = above_cnt != 3'd0 && above_cnt != 3'd4;
  assign done_all = phase && n == s;

  logic out_free;
  logic go_div;
  logic go_on;
  logic emit_go;
  assign out_free = !out_v || point.ready;
  assign go_div = !walked && (kind == KIND_CELL ? (cnt_ok && hit) :
                  (kind <= KIND_RIGHT && ((pa > thr) != (pb > thr))));
  assign go_on = kind == KIND_CELL && cnt_ok && !walked && !done_all;
  // a held point goes out once the next crossing is found or the item ends
  assign emit_go = pending && out_free &&
                   ((state == ST_TEST && go_div) || state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    dctl = '{start: 1'b0, busy: dbusy};
    unique case (state)
      ST_IDLE: if (item.valid && item.ready) state_next = ST_STEP;
      ST_STEP: begin
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (out_free) begin
          if (go_div) begin
            dctl.start = 1'b1;
            state_next = ST_DIV;
          end else if (go_on) begin
            state_next = ST_TEST;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_DIV: if (!dbusy && !gbusy) state_next = ST_STEP;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  logic signed [WW-1:0] fq;
  assign fq = WW'(dq);
  assign gval = WW'(gq);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0; pending <= 1'b0;
    end else begin
      if (emit_go) begin
        out_v <= 1'b1; ox_r <= sat(pend_x); oy_r <= sat(pend_y);
        olast <= state == ST_OUT;
      end else if (point.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (item.valid && item.ready) begin
          kind <= item.kind; pa <= item.pixel_a; pb <= item.pixel_b;
          pc <= item.pixel_c; pd <= item.pixel_d;
          bx <= WW'(item.cell_col) * WW'(ONE) - WW'(tw) * WW'(ONE / 2) + WW'(ONE / 2);
          by <= WW'(item.cell_row) * WW'(ONE) - WW'(th) * WW'(ONE / 2) + WW'(ONE / 2);
          cxs <= WW'(tw) * (ONE / 2);
          cys <= WW'(th) * (ONE / 2);
          s <= ssteps == 5'd0 ? NW'(1) :
               (32'(ssteps) > MAX_SUB_STEPS ? NW'(MAX_SUB_STEPS) : NW'(ssteps));
          n <= '0; phase <= 1'b0; walked <= 1'b0;
          if (item.kind >= KIND_TL && item.kind <= KIND_BR) begin
            if (item.pixel_a > thr) begin
              pending <= 1'b1;
              pend_x <= (item.kind == KIND_TL || item.kind == KIND_BL) ?
                        -(WW'(tw) * (ONE / 2)) : WW'(tw) * (ONE / 2);
              pend_y <= (item.kind == KIND_TL || item.kind == KIND_TR) ?
                        -(WW'(th) * (ONE / 2)) : WW'(th) * (ONE / 2);
            end
          end
        end
        ST_TEST: if (out_free) begin
          if (go_div) pending <= 1'b0;
          walked <= kind != KIND_CELL || done_all;
          pend_sel <= kind == KIND_CELL ? {1'b0, phase} : 2'd2;
          if (phase) n <= n + 1'b1;
          phase <= !phase;
        end
        ST_DIV: if (!dbusy && !gbusy) begin
          pending <= 1'b1;
          unique case (pend_sel)
            2'd0: begin pend_x <= bx + fq; pend_y <= by + gval; end
            2'd1: begin pend_x <= bx + gval; pend_y <= by + fq; end
            default: begin
              unique case (kind)
                KIND_TOP: begin pend_x <= bx + fq; pend_y <= -cys; end
                KIND_BOTTOM: begin pend_x <= bx + fq; pend_y <= cys; end
                KIND_LEFT: begin pend_x <= -cxs; pend_y <= by + fq; end
                default: begin pend_x <= cxs; pend_y <= by + fq; end
              endcase
            end
          endcase
        end
        ST_OUT: if (out_free && pending) begin
          pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
